### rtl/qn_pkg.sv
// ----------------------------------------------------------------------------
// qn_pkg
// Shared types and constants for the quaternion normaliser.
// ----------------------------------------------------------------------------
package qn_pkg;

  localparam int unsigned NumComp  = 4;
  localparam int unsigned CompW    = 16;
  localparam int unsigned SqW      = 31;
  localparam int unsigned SumW     = 33;
  localparam int unsigned QW       = 17;
  localparam int unsigned NumSteps = 16;

  // One classified request handed from the front to the back
  typedef struct packed {
    logic [NumComp-1:0][CompW-1:0] comp;
    logic [NumComp-1:0][SqW-1:0]   sq;
    logic [SumW-1:0]               sum;
    logic                          zero;
  } qn_item_t;

endpackage

### rtl/quaternion_normalize.sv
// ----------------------------------------------------------------------------
// quaternion_normalize
// Scales a Q1.14 quaternion to unit length with round-to-nearest.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid_i/in_ready_o carries comp_w/x/y/z_i, signed.
//   Output channel out_valid_o/out_ready_i carries unit_w/x/y/z_o, each
//   component times 2^FRAC_BITS / magnitude, and zero_length_o, which is set
//   (with zero components) for an all-zero quaternion.
//   Throughput: one request per cycle while the receiver keeps up. Each
//   request passes the square stage, the queue, setup, sixteen search steps
//   and the output register on its way from acceptance to out_valid_o.
//   Reset empties every stage and the queue; out_valid_o drops at once.
//   When the receiver stalls, the back pipeline holds, the two-entry queue
//   fills, and then in_ready_o falls; nothing is lost.
// ----------------------------------------------------------------------------
module quaternion_normalize import qn_pkg::*; #(
  parameter int unsigned FRAC_BITS = 14
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [CompW-1:0]  comp_w_i,
  input  logic [CompW-1:0]  comp_x_i,
  input  logic [CompW-1:0]  comp_y_i,
  input  logic [CompW-1:0]  comp_z_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [CompW-1:0]  unit_w_o,
  output logic [CompW-1:0]  unit_x_o,
  output logic [CompW-1:0]  unit_y_o,
  output logic [CompW-1:0]  unit_z_o,
  output logic              zero_length_o
);

  logic [NumComp-1:0][CompW-1:0] comp, unit;
  qn_item_t                      f_item, b_item;
  logic                          push, full, pop, empty;

  assign comp[0] = comp_w_i;
  assign comp[1] = comp_x_i;
  assign comp[2] = comp_y_i;
  assign comp[3] = comp_z_i;

  qn_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o,
    .comp_i(comp), .push_o(push), .full_i(full), .item_o(f_item)
  );

  qn_fifo u_fifo (
    .clk_i, .rst_ni, .push_i(push), .item_i(f_item), .full_o(full),
    .pop_i(pop), .empty_o(empty), .item_o(b_item)
  );

  qn_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk_i, .rst_ni, .empty_i(empty), .item_i(b_item), .pop_o(pop),
    .out_valid_o, .out_ready_i, .unit_o(unit), .zero_o(zero_length_o)
  );

  assign unit_w_o = unit[0];
  assign unit_x_o = unit[1];
  assign unit_y_o = unit[2];
  assign unit_z_o = unit[3];

endmodule

### rtl/qn_front.sv
// ----------------------------------------------------------------------------
// qn_front
// Input stage: squares the four components, then sums them and flags a
// zero-length quaternion on the way into the queue.
// ----------------------------------------------------------------------------
module qn_front import qn_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [NumComp-1:0][CompW-1:0] comp_i,
  output logic                          push_o,
  input  logic                          full_i,
  output qn_item_t                      item_o
);

  logic                          valid_q;
  logic [NumComp-1:0][CompW-1:0] comp_q;
  logic [NumComp-1:0][SqW-1:0]   sq_q;
  logic                          adv;
  logic [SumW-1:0]               sum;

  assign adv        = !valid_q || !full_i;
  assign in_ready_o = adv;
  assign push_o     = valid_q && !full_i;

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv) begin
      valid_q <= in_valid_i;
    end
  end

  // squares, one multiplier per component
  always_ff @(posedge clk_i) begin
    if (adv && in_valid_i) begin
      comp_q <= comp_i;
      for (int i = 0; i < NumComp; i++) begin
        sq_q[i] <= SqW'($signed(comp_i[i]) * $signed(comp_i[i]));
      end
    end
  end

  // sum of squares
  always_comb begin
    sum = '0;
    for (int i = 0; i < NumComp; i++) begin
      sum = sum + SumW'(sq_q[i]);
    end
  end

  assign item_o.comp = comp_q;
  assign item_o.sq   = sq_q;
  assign item_o.sum  = sum;
  assign item_o.zero = (sum == '0);

endmodule

### rtl/qn_fifo.sv
// ----------------------------------------------------------------------------
// qn_fifo
// Two-entry queue between the front and the back.
// ----------------------------------------------------------------------------
module qn_fifo import qn_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  qn_item_t item_i,
  output logic     full_o,
  input  logic     pop_i,
  output logic     empty_o,
  output qn_item_t item_o
);

  qn_item_t   mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign item_o  = mem_q[rd_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= !wr_q;
      if (pop_i)  rd_q <= !rd_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= item_i;
  end

endmodule

### rtl/qn_back.sv
// ----------------------------------------------------------------------------
// qn_back
// Sixteen-step pipelined bit search for round(|c| * 2^F / sqrt(S)). Each
// step tries one result bit using shifts and adds on (2q-1)^2 * S, then an
// output register applies sign, saturation and the zero case.
// ----------------------------------------------------------------------------
module qn_back import qn_pkg::*; #(
  parameter int unsigned FRAC_BITS = 14
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          empty_i,
  input  qn_item_t                      item_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [NumComp-1:0][CompW-1:0] unit_o,
  output logic                          zero_o
);

  localparam int unsigned PW = (2 * FRAC_BITS + 36 > 68) ? 2 * FRAC_BITS + 36 : 68;
  localparam int unsigned NS = NumSteps + 1;

  logic                 en;
  logic                 v_q    [NS];
  logic                 zero_q [NS];
  logic signed [PW-1:0] s_q    [NS];
  logic                 neg_q  [NS][NumComp];
  logic [QW-1:0]        q_q    [NS][NumComp];
  logic signed [PW-1:0] a_q    [NS][NumComp];
  logic signed [PW-1:0] p_q    [NS][NumComp];
  logic signed [PW-1:0] r_q    [NS][NumComp];
  logic                 ov_q;

  assign en          = !ov_q || out_ready_i;
  assign pop_o       = en && !empty_i;
  assign out_valid_o = ov_q;

  // valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < NS; j++) v_q[j] <= 1'b0;
      ov_q <= 1'b0;
    end else if (en) begin
      v_q[0] <= !empty_i;
      for (int j = 1; j < NS; j++) v_q[j] <= v_q[j-1];
      ov_q <= v_q[NS-1];
    end
  end

  // search setup: q = 0, A = -S, P = S, R = 4 c^2 2^(2F)
  always_ff @(posedge clk_i) begin
    if (en) begin
      zero_q[0] <= item_i.zero;
      s_q[0]    <= PW'(item_i.sum);
      for (int l = 0; l < NumComp; l++) begin
        neg_q[0][l] <= item_i.comp[l][CompW-1];
        q_q[0][l]   <= '0;
        a_q[0][l]   <= -$signed(PW'(item_i.sum));
        p_q[0][l]   <= $signed(PW'(item_i.sum));
        r_q[0][l]   <= $signed(PW'(item_i.sq[l]) << (2 * FRAC_BITS + 2));
      end
    end
  end

  // one result bit per stage
  for (genvar j = 0; j < NumSteps; j++) begin : g_step
    localparam int unsigned K = NumSteps - 1 - j;
    for (genvar l = 0; l < NumComp; l++) begin : g_lane
      logic signed [PW-1:0] cand;
      logic                 ok;
      assign cand = p_q[j][l] + (a_q[j][l] <<< (K + 2)) + (s_q[j] <<< (2 * K + 2));
      assign ok   = !q_q[j][l][QW-1] && (cand <= r_q[j][l]);
      always_ff @(posedge clk_i) begin
        if (en) begin
          neg_q[j+1][l] <= neg_q[j][l];
          r_q[j+1][l]   <= r_q[j][l];
          if (ok) begin
            q_q[j+1][l] <= q_q[j][l] | (QW'(1) << K);
            p_q[j+1][l] <= cand;
            a_q[j+1][l] <= a_q[j][l] + (s_q[j] <<< (K + 1));
          end else begin
            q_q[j+1][l] <= q_q[j][l];
            p_q[j+1][l] <= p_q[j][l];
            a_q[j+1][l] <= a_q[j][l];
          end
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        s_q[j+1]    <= s_q[j];
        zero_q[j+1] <= zero_q[j];
      end
    end
  end

  // output register: sign, saturation, zero quaternion
  // a magnitude of 2^15 or more only arises for wide fractions
  always_ff @(posedge clk_i) begin
    if (en) begin
      zero_o <= zero_q[NS-1];
      for (int l = 0; l < NumComp; l++) begin
        if (zero_q[NS-1]) begin
          unit_o[l] <= '0;
        end else if (neg_q[NS-1][l]) begin
          if (q_q[NS-1][l][CompW-1]) begin
            unit_o[l] <= 16'h8000;
          end else begin
            unit_o[l] <= CompW'(QW'(0) - q_q[NS-1][l]);
          end
        end else if (q_q[NS-1][l][CompW-1]) begin
          unit_o[l] <= 16'h7fff;
        end else begin
          unit_o[l] <= q_q[NS-1][l][CompW-1:0];
        end
      end
    end
  end

endmodule

### rtl/qn_checker.sv
// ----------------------------------------------------------------------------
// qn_checker
// Port-level checks on the quaternion normaliser, bound to the top level.
// ----------------------------------------------------------------------------
module qn_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [15:0] unit_w_o,
  input logic [15:0] unit_x_o,
  input logic [15:0] unit_y_o,
  input logic [15:0] unit_z_o,
  input logic        zero_length_o
);

  // a zero quaternion gives zero components
  a_zero_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && zero_length_o |->
      unit_w_o == 16'h0 && unit_x_o == 16'h0 && unit_y_o == 16'h0 && unit_z_o == 16'h0)
    else $error("zero_length set with nonzero components");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o)
    else $error("output valid during reset");

  // a stalled request holds its valid and its w and z components
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(unit_w_o) && $stable(unit_z_o))
    else $error("stalled request changed");

endmodule

bind quaternion_normalize qn_checker u_qn_checker (
  .clk_i, .rst_ni, .out_valid_o, .out_ready_i,
  .unit_w_o, .unit_x_o, .unit_y_o, .unit_z_o, .zero_length_o
);

### test/tb_quaternion_normalize.sv
// ----------------------------------------------------------------------------
// tb_quaternion_normalize
// Self-checking bench for the quaternion normaliser: directed corner cases
// then random quaternions, predicted by an exact integer search, with
// random stalls on both channels and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_quaternion_normalize;
  import qn_pkg::*;

  localparam int unsigned FracBits = 14;
  localparam int          NumRand  = 1830;
  localparam int          Latency  = 19;

  typedef struct packed {
    logic [CompW-1:0] w;
    logic [CompW-1:0] x;
    logic [CompW-1:0] y;
    logic [CompW-1:0] z;
  } quat_t;

  typedef struct packed {
    logic [CompW-1:0] w;
    logic [CompW-1:0] x;
    logic [CompW-1:0] y;
    logic [CompW-1:0] z;
    logic             zero;
  } unit_t;

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_ready_o;
  logic [CompW-1:0] comp_w_i, comp_x_i, comp_y_i, comp_z_i;
  logic             out_valid_o;
  logic             out_ready_i;
  logic [CompW-1:0] unit_w_o, unit_x_o, unit_y_o, unit_z_o;
  logic             zero_length_o;

  quat_t pending_q[$];
  unit_t unit_expected_q[$];
  int    mismatches = 0;
  int    results_seen = 0;
  int    zero_seen = 0;
  bit    stim_done;
  bit    calm;
  bit    hold_off;
  bit    in_taken;

  quaternion_normalize #(.FRAC_BITS(FracBits)) dut (.*);

  // clock and single reset
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  // scaled, rounded magnitude of one component, by exact binary search
  function automatic logic [CompW-1:0] scale_comp(logic [CompW-1:0] c,
                                                  logic [63:0] s);
    logic signed [16:0] cs;
    logic [16:0]        m;
    logic [31:0]        lo, hi, mid;
    logic [63:0]        t;
    logic [127:0]       lhs, rhs;
    cs = $signed(c);
    m  = cs < 0 ? 17'(-cs) : 17'(cs);
    lo = 0;
    hi = 32768;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      t   = 2 * 64'(mid) - 1;
      lhs = 128'(t) * 128'(t) * 128'(s);
      rhs = (128'(4) * 128'(m) * 128'(m)) << (2 * FracBits);
      if (lhs <= rhs) lo = mid;
      else hi = mid - 1;
    end
    if (cs < 0) return 16'(32'h10000 - lo);
    if (lo > 32767) lo = 32767;
    return lo[15:0];
  endfunction

  function automatic unit_t normalise(quat_t q);
    unit_t       u;
    logic [63:0] s;
    s = 64'($signed(q.w) * $signed(q.w)) + 64'($signed(q.x) * $signed(q.x))
      + 64'($signed(q.y) * $signed(q.y)) + 64'($signed(q.z) * $signed(q.z));
    u = '0;
    if (s == 0) begin
      u.zero = 1'b1;
    end else begin
      u.w = scale_comp(q.w, s);
      u.x = scale_comp(q.x, s);
      u.y = scale_comp(q.y, s);
      u.z = scale_comp(q.z, s);
    end
    return u;
  endfunction

  function automatic logic [CompW-1:0] rand_comp();
    case ($urandom_range(0, 7))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return '0;
      3:       return 16'($urandom_range(0, 15)) - 16'd8;
      default: return 16'($urandom);
    endcase
  endfunction

  // stimulus: corner cases, then random quaternions
  initial begin
    quat_t q;
    pending_q.push_back('{16'h0000, 16'h0000, 16'h0000, 16'h0000});
    pending_q.push_back('{16'h4000, 16'h0000, 16'h0000, 16'h0000});
    pending_q.push_back('{16'h0000, 16'hc000, 16'h0000, 16'h0000});
    pending_q.push_back('{16'h8000, 16'h0000, 16'h0000, 16'h0000});
    pending_q.push_back('{16'h7fff, 16'h0000, 16'h0000, 16'h0000});
    pending_q.push_back('{16'h0000, 16'h0000, 16'h0001, 16'h0000});
    pending_q.push_back('{16'h0000, 16'h0000, 16'h0000, 16'hffff});
    pending_q.push_back('{16'h8000, 16'h8000, 16'h8000, 16'h8000});
    pending_q.push_back('{16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff});
    pending_q.push_back('{16'h7fff, 16'h8000, 16'h7fff, 16'h8000});
    pending_q.push_back('{16'h0001, 16'h0001, 16'h0001, 16'h0001});
    pending_q.push_back('{16'hffff, 16'h0001, 16'hffff, 16'h0001});
    pending_q.push_back('{16'h0003, 16'h0004, 16'h0000, 16'h0000});
    pending_q.push_back('{16'h7fff, 16'h0001, 16'h0000, 16'h0000});
    pending_q.push_back('{16'h0001, 16'h8000, 16'h0001, 16'h0000});
    pending_q.push_back('{16'h2000, 16'h2000, 16'he000, 16'he000});
    pending_q.push_back('{16'h5555, 16'haaaa, 16'h0000, 16'h1234});
    for (int i = 0; i < NumRand; i++) begin
      q.w = rand_comp();
      q.x = rand_comp();
      q.y = rand_comp();
      q.z = rand_comp();
      pending_q.push_back(q);
    end
  end

  // long receiver hold-off while the sender keeps offering requests
  initial begin
    hold_off = 1'b0;
    wait (rst_ni);
    repeat (300) @(posedge clk_i);
    hold_off = 1'b1;
    repeat (80) @(posedge clk_i);
    hold_off = 1'b0;
  end

  // input handshake as seen at the rising edge
  always @(posedge clk_i) begin
    in_taken <= rst_ni && in_valid_i && in_ready_o;
  end

  // driver
  int in_gap;
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      {comp_w_i, comp_x_i, comp_y_i, comp_z_i} <= '0;
      in_gap <= 0;
    end else if (!in_valid_i || in_taken) begin
      // previous request taken at the last rising edge, or none offered
      if (in_valid_i) void'(pending_q.pop_front());
      if (in_gap > 0) begin
        in_valid_i <= 1'b0;
        in_gap <= in_gap - 1;
      end else if (!calm && $urandom_range(0, 15) == 0) begin
        in_valid_i <= 1'b0;
        in_gap <= $urandom_range(0, 5);
      end else if (pending_q.size() > 0) begin
        in_valid_i <= 1'b1;
        {comp_w_i, comp_x_i, comp_y_i, comp_z_i} <= pending_q[0];
      end else begin
        in_valid_i <= 1'b0;
        stim_done <= 1'b1;
      end
    end
  end

  // receiver stalls
  int out_gap;
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      out_gap <= 0;
    end else if (hold_off) begin
      out_ready_i <= 1'b0;
    end else if (out_gap > 0) begin
      out_ready_i <= 1'b0;
      out_gap <= out_gap - 1;
    end else if (!calm && $urandom_range(0, 11) == 0) begin
      out_ready_i <= 1'b0;
      out_gap <= $urandom_range(0, 5);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // monitor: predict at input acceptance, check at output acceptance
  always @(posedge clk_i) begin
    unit_t got, want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o)
        unit_expected_q.push_back(normalise('{comp_w_i, comp_x_i, comp_y_i, comp_z_i}));
      if (out_valid_o && out_ready_i) begin
        got = '{unit_w_o, unit_x_o, unit_y_o, unit_z_o, zero_length_o};
        results_seen++;
        if (zero_length_o) zero_seen++;
        if (unit_expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", got);
        end else begin
          want = unit_expected_q.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp w=%h x=%h y=%h z=%h zl=%b got w=%h x=%h y=%h z=%h zl=%b",
                       want.w, want.x, want.y, want.z, want.zero,
                       got.w, got.x, got.y, got.z, got.zero);
          end
        end
      end
    end
  end

  // end of run
  initial begin
    calm = 1'b0;
    wait (rst_ni);
    wait (pending_q.size() < 300);
    calm = 1'b1;
    wait (stim_done);
    wait (unit_expected_q.size() == 0);
    repeat (Latency + 10) @(posedge clk_i);
    $display("Checked %0d normalised quaternions, %0d of them zero-length,", results_seen,
             zero_seen);
    $display("including signed extremes and a long output stall.");
    if (mismatches == 0 && unit_expected_q.size() == 0) begin
      $display("PASS quaternion_normalize");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("FAIL quaternion_normalize");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("FAIL quaternion_normalize");
    $finish;
  end

endmodule
